// ===== hdl/homogeneous_point_vector_transform_defines.svh =====
// Assertion macros shared by the homogeneous transform RTL.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef HOMOGENEOUS_POINT_VECTOR_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_POINT_VECTOR_TRANSFORM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HPVT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HPVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hpvt_pkg.sv =====
// Shared widths, codes and the pipeline control struct of the homogeneous transform.
// No dependencies; used by hpvt_div and the top level.
package hpvt_pkg;

    localparam int COORD_W   = 32;
    localparam int LANES     = 3;
    localparam int ROWS      = 4;
    localparam int ROW_W     = 3;
    localparam int COL_X     = 0;
    localparam int COL_Y     = 1;
    localparam int COL_Z     = 2;
    localparam int CFG_W     = 64;
    localparam int N_CFG     = 8;
    localparam int CFG_IDX_W = 4;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int QUO_W     = COORD_W;

    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic {
        REQ_POINT = 1'b0,
        REQ_DIR   = 1'b1
    } t_req;

    typedef struct packed {
        logic valid;
        logic wzero;
    } t_ctl;

endpackage

// ===== hdl/hpvt_div.sv =====
// Pipelined restoring divider for three lanes with a shared divisor, rounding and saturation.
// Depends on hpvt_pkg and the assertion macros in the defines header.
`include "homogeneous_point_vector_transform_defines.svh"

module hpvt_div #(
    parameter int FRAC_BITS = 16,
    parameter int MAG_W     = 66
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_ce,
    input  hpvt_pkg::t_ctl                                         i_ctl,
    input  logic [hpvt_pkg::LANES-1:0]                             i_neg,
    input  logic [hpvt_pkg::LANES-1:0][MAG_W-1:0]                  i_mag,
    input  logic [MAG_W-1:0]                                       i_den,
    output logic                                                   o_valid,
    output logic [hpvt_pkg::LANES-1:0][hpvt_pkg::COORD_W-1:0]      o_res,
    output logic                                                   o_flag
);
    import hpvt_pkg::*;

    localparam int CMP_W = MAG_W + QUO_W;

    logic                    r_p_valid;
    logic                    r_p_wzero;
    logic [LANES-1:0]        r_p_neg;
    logic [CMP_W-1:0]        r_p_num [LANES];
    logic [MAG_W-1:0]        r_p_den;

    logic [QUO_W:0]          r_valid;
    logic [QUO_W:0]          r_wzero;
    logic [LANES-1:0]        r_neg [QUO_W+1];
    logic [LANES-1:0]        r_ovf [QUO_W+1];
    logic [MAG_W-1:0]        r_den [QUO_W+1];
    logic [CMP_W-1:0]        r_rem [QUO_W+1][LANES];
    logic [CMP_W-1:0]        n_rem [QUO_W+1][LANES];
    logic [QUO_W-1:0]        r_quo [QUO_W+1][LANES];
    logic [QUO_W-1:0]        n_quo [QUO_W+1][LANES];
    logic [LANES-1:0]        n_ovf;

    logic                                r_out_valid;
    logic [LANES-1:0][COORD_W-1:0]       r_out_res;
    logic                                r_out_flag;
    logic [LANES-1:0][COORD_W-1:0]       n_out_res;
    logic                                n_out_flag;
    logic                                w_rem_ok;

    // The rounding offset is half the divisor, so the floor quotient below rounds
    // to nearest with ties away from zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_ce) begin
            r_p_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p_wzero <= i_ctl.wzero;
            r_p_neg   <= i_neg;
            r_p_den   <= i_den;
            for (int l = 0; l < LANES; l++) begin
                r_p_num[l] <= (CMP_W'(i_mag[l]) << FRAC_BITS) + CMP_W'(i_den >> 1);
            end
        end
    end

    // Each stage settles one quotient bit, most significant first.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_ovf[l]    = r_p_num[l] >= {r_p_den, {QUO_W{1'b0}}};
            n_rem[0][l] = r_p_num[l];
            n_quo[0][l] = '0;
        end
        for (int k = 0; k < QUO_W; k++) begin
            for (int l = 0; l < LANES; l++) begin
                if (r_rem[k][l] >= (CMP_W'(r_den[k]) << (QUO_W - 1 - k))) begin
                    n_rem[k+1][l] = r_rem[k][l] - (CMP_W'(r_den[k]) << (QUO_W - 1 - k));
                    n_quo[k+1][l] = r_quo[k][l] | (QUO_W'(1) << (QUO_W - 1 - k));
                end else begin
                    n_rem[k+1][l] = r_rem[k][l];
                    n_quo[k+1][l] = r_quo[k][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ce) begin
            r_valid <= {r_valid[QUO_W-1:0], r_p_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_wzero  <= {r_wzero[QUO_W-1:0], r_p_wzero};
            r_neg[0] <= r_p_neg;
            r_ovf[0] <= n_ovf;
            r_den[0] <= r_p_den;
            for (int k = 1; k <= QUO_W; k++) begin
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_den[k] <= r_den[k-1];
            end
            for (int k = 0; k <= QUO_W; k++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_quo[k][l] <= n_quo[k][l];
                end
            end
        end
    end

    // A negative result may reach the most negative value; a positive one may not.
    always_comb begin
        logic [QUO_W-1:0] q;
        logic             sat;
        n_out_flag = r_wzero[QUO_W];
        for (int l = 0; l < LANES; l++) begin
            q   = r_quo[QUO_W][l];
            sat = r_ovf[QUO_W][l] ||
                  (r_neg[QUO_W][l] ? (q[QUO_W-1] && (q[QUO_W-2:0] != '0)) : q[QUO_W-1]);
            if (r_wzero[QUO_W]) begin
                n_out_res[l] = '0;
            end else if (sat) begin
                n_out_res[l] = r_neg[QUO_W][l] ? SAT_MIN : SAT_MAX;
                n_out_flag   = 1'b1;
            end else begin
                n_out_res[l] = r_neg[QUO_W][l] ? -q : q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ce) begin
            r_out_valid <= r_valid[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_out_res  <= n_out_res;
            r_out_flag <= n_out_flag;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out_res;
    assign o_flag  = r_out_flag;

    always_comb begin
        w_rem_ok = 1'b1;
        for (int l = 0; l < LANES; l++) begin
            if (!r_ovf[QUO_W][l] && (r_rem[QUO_W][l] >= CMP_W'(r_den[QUO_W]))) begin
                w_rem_ok = 1'b0;
            end
        end
    end

    `HPVT_ASSERT_SAME(a_rem_below_den, i_clk, i_rst_n, r_valid[QUO_W], w_rem_ok, "remainder not below divisor")
    `HPVT_ASSERT_NEXT(a_valid_reaches_out, i_clk, i_rst_n, i_ce && r_valid[QUO_W], r_out_valid, "valid item lost at output")
    `HPVT_ASSERT_NEXT(a_pipe_frozen, i_clk, i_rst_n, !i_ce, r_valid == $past(r_valid), "pipeline moved while stalled")

endmodule

// ===== hdl/homogeneous_point_vector_transform.sv =====
// A result beat passes stages a to e, the divider's input stage and bit stages, and its output register.
// Throughput: one beat per cycle; the whole pipeline advances together and holds while
// the output beat waits, so the bit-per-stage divider sets the depth but not the rate.
// Reset (synchronous, active low) empties the pipeline and loads the identity matrix.
// Depends on hpvt_pkg and hpvt_div.
module homogeneous_point_vector_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_s_tvalid,
    output logic                                            o_s_tready,
    // coord_x [31:0], coord_y [63:32], coord_z [95:64]
    input  logic [hpvt_pkg::LANES*hpvt_pkg::COORD_W-1:0]    i_s_tdata,
    // req_type [0]
    input  logic                                            i_s_tuser,
    output logic                                            o_m_tvalid,
    input  logic                                            i_m_tready,
    // out_x [31:0], out_y [63:32], out_z [95:64]
    output logic [hpvt_pkg::LANES*hpvt_pkg::COORD_W-1:0]    o_m_tdata,
    // overflow_flag [0]
    output logic                                            o_m_tuser,
    input  logic                                            i_cfg_valid,
    output logic                                            o_cfg_ready,
    input  logic [hpvt_pkg::CFG_IDX_W-1:0]                  i_cfg_index,
    input  logic [hpvt_pkg::CFG_W-1:0]                      i_cfg_data
);
    import hpvt_pkg::*;

    localparam logic [COORD_W-1:0] COEF_ONE  = COORD_W'(1) << FRAC_BITS;
    localparam logic [COORD_W-1:0] COEF_ZERO = '0;
    localparam logic [CFG_W-1:0]   CFG_RST [N_CFG] = '{
        {COEF_ZERO, COEF_ONE}, '0, {COEF_ONE, COEF_ZERO}, '0,
        '0, {COEF_ZERO, COEF_ONE}, '0, {COEF_ONE, COEF_ZERO}
    };
    localparam logic signed [SUM_W-1:0] DIR_DEN = SUM_W'(1) << (2 * FRAC_BITS);

    logic                          w_ce;
    logic [CFG_W-1:0]              r_cfg [N_CFG];

    logic                          r_a_valid;
    t_req                          r_a_req;
    logic signed [COORD_W-1:0]     r_a_crd [LANES];

    logic                          r_b_valid;
    logic                          r_b_point;
    logic signed [PROD_W-1:0]      r_b_prod [ROWS][LANES];
    logic signed [PROD_W-1:0]      n_b_prod [ROWS][LANES];
    logic signed [COORD_W-1:0]     r_b_trn [ROWS];
    logic signed [COORD_W-1:0]     n_b_trn [ROWS];

    logic                          r_c_valid;
    logic                          r_c_point;
    logic signed [SUM_W-1:0]       r_c_sa [ROWS];
    logic signed [SUM_W-1:0]       r_c_sb [ROWS];

    logic                          r_d_valid;
    logic                          r_d_point;
    logic signed [SUM_W-1:0]       r_d_sum [ROWS];

    t_ctl                          r_e_ctl;
    logic [LANES-1:0]              r_e_neg;
    logic [LANES-1:0][SUM_W-1:0]   r_e_mag;
    logic [SUM_W-1:0]              r_e_den;
    t_ctl                          n_e_ctl;
    logic [LANES-1:0]              n_e_neg;
    logic [LANES-1:0][SUM_W-1:0]   n_e_mag;
    logic [SUM_W-1:0]              n_e_den;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_CFG; i++) begin
                r_cfg[i] <= CFG_RST[i];
            end
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index < CFG_IDX_W'(N_CFG))) begin
            r_cfg[i_cfg_index[$clog2(N_CFG)-1:0]] <= i_cfg_data;
        end
    end

    // The pipeline moves as one whenever the output register is free or being drained.
    assign w_ce       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_ctl   <= '0;
        end else if (w_ce) begin
            r_a_valid <= i_s_tvalid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_ctl   <= n_e_ctl;
        end
    end

    // Even registers hold the x and y columns of a row, odd ones z and translation.
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            n_b_prod[r][COL_X] = $signed(r_cfg[2*r][COORD_W-1:0]) * r_a_crd[COL_X];
            n_b_prod[r][COL_Y] = $signed(r_cfg[2*r][CFG_W-1:COORD_W]) * r_a_crd[COL_Y];
            n_b_prod[r][COL_Z] = $signed(r_cfg[2*r+1][COORD_W-1:0]) * r_a_crd[COL_Z];
            n_b_trn[r]         = (r_a_req == REQ_POINT) ?
                                 $signed(r_cfg[2*r+1][CFG_W-1:COORD_W]) : '0;
        end
    end

    // A direction uses a fixed divisor of one in the doubled fraction format, so both
    // kinds share the divider; a point whose w is exactly one gives the same result.
    always_comb begin
        logic signed [SUM_W-1:0] den;
        den           = r_d_point ? r_d_sum[ROW_W] : DIR_DEN;
        n_e_ctl.valid = r_d_valid;
        n_e_ctl.wzero = r_d_point && (r_d_sum[ROW_W] == '0);
        n_e_den       = den[SUM_W-1] ? -den : den;
        for (int l = 0; l < LANES; l++) begin
            n_e_mag[l] = r_d_sum[l][SUM_W-1] ? -r_d_sum[l] : r_d_sum[l];
            n_e_neg[l] = r_d_sum[l][SUM_W-1] ^ den[SUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_req <= t_req'(i_s_tuser);
            for (int l = 0; l < LANES; l++) begin
                r_a_crd[l] <= i_s_tdata[l*COORD_W +: COORD_W];
            end

            r_b_point <= (r_a_req == REQ_POINT);
            r_b_prod  <= n_b_prod;
            r_b_trn   <= n_b_trn;

            r_c_point <= r_b_point;
            for (int r = 0; r < ROWS; r++) begin
                r_c_sa[r] <= SUM_W'(r_b_prod[r][COL_X]) + SUM_W'(r_b_prod[r][COL_Y]);
                r_c_sb[r] <= SUM_W'(r_b_prod[r][COL_Z]) + (SUM_W'(r_b_trn[r]) <<< FRAC_BITS);
            end

            r_d_point <= r_c_point;
            for (int r = 0; r < ROWS; r++) begin
                r_d_sum[r] <= r_c_sa[r] + r_c_sb[r];
            end

            r_e_neg <= n_e_neg;
            r_e_mag <= n_e_mag;
            r_e_den <= n_e_den;
        end
    end

    hpvt_div #(
        .FRAC_BITS (FRAC_BITS),
        .MAG_W     (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_ctl   (r_e_ctl),
        .i_neg   (r_e_neg),
        .i_mag   (r_e_mag),
        .i_den   (r_e_den),
        .o_valid (o_m_tvalid),
        .o_res   (o_m_tdata),
        .o_flag  (o_m_tuser)
    );

endmodule
